>>> design/scel_pkg.sv
`default_nettype none

package scel_pkg;

   // Fixed sample format: signed Q16.16.
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COUNT_W    = 16;

   // Widths of the shared iterative unit.
   localparam int WIDE_W = 72;
   localparam int OPB_W  = 36;
   localparam int REM_W  = 40;
   localparam int ROOT_W = 36;
   localparam int CNT_W  = 6;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_MODE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      MODE_MAXIMA,
      MODE_MINIMA,
      MODE_RISING,
      MODE_FALLING
   } detect_mode_type;

   typedef enum logic [1:0] {
      IU_MUL,
      IU_SQRT,
      IU_DIV
   } iu_op_type;

   typedef struct packed {
      logic      start;
      iu_op_type op;
   } iu_cmd_type;

endpackage

`default_nettype wire

>>> design/sampled_curve_event_locator_top.sv
// Sequence: a sample that gives no event passes through evaluate, decide and finish and
// frees the block; an extremum adds the divide (where the curvature is not zero) and the
// placing multiply, and a zero crossing adds two multiplies, the root and the root choice.
// Throughput: one sample at a time; the shared shift-add, root and divide unit does one
// step per cycle while busy, so its multiplies, the 36-step root and 16-step divide set it.
// Reset (synchronous, active high) clears the window, the event count and the output,
// and sets the mode to maxima and the limit to 64.
`default_nettype none

module sampled_curve_event_locator_top import scel_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_x_value,
   input  logic signed [DATA_WIDTH-1:0] req_y_value,
   input  logic                         req_last_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_event_x,
   output logic [COUNT_W-1:0]           rsp_event_count,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [COUNT_W-1:0]           csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DECIDE,
      ST_MUL_B,
      ST_MUL_AC,
      ST_SQRT,
      ST_ROOTS,
      ST_DIV,
      ST_PLACE,
      ST_PLACE_MUL,
      ST_FINISH
   } state_type;

   state_type state_ff;

   detect_mode_type      mode_ff;
   logic [COUNT_W-1:0]   limit_ff;
   logic [COUNT_W-1:0]   events_found_ff;
   logic [1:0]           samples_seen_ff;

   logic signed [DATA_WIDTH-1:0] older_x_ff, older_y_ff, middle_x_ff, middle_y_ff;
   logic signed [DATA_WIDTH-1:0] x2_ff, y2_ff;
   logic                         last_ff;

   logic signed [34:0] a2_ff;
   logic signed [33:0] b2_ff;
   logic signed [32:0] dx_ff;
   logic signed [37:0] r1_ff, r2_ff;
   logic [WIDE_W-1:0]  d_ff;
   logic               hit_ff;
   logic               tneg_ff;
   logic [FRAC_BITS-1:0] tq_ff;
   logic signed [DATA_WIDTH-1:0] place_x_ff;

   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_x_ff;
   logic [COUNT_W-1:0]           rsp_count_ff;

   iu_cmd_type        iu_cmd_ff;
   logic [WIDE_W-1:0] iu_opa_ff;
   logic [OPB_W-1:0]  iu_opb_ff;
   logic              iu_done;
   logic [WIDE_W-1:0] iu_result;

   logic signed [34:0] a2_in;
   logic signed [33:0] b2_in;
   logic signed [32:0] dx_in;
   logic [34:0] a2_mag;
   logic [33:0] b2_mag;
   logic [32:0] dx_mag;
   logic [31:0] y1_mag;
   logic [35:0] den;
   logic [37:0] r1_mag, r2_mag;
   logic [WIDE_W:0] d_diff;
   logic [WIDE_W-1:0] d_sum;
   logic        same_sign;
   logic        window_ok;
   logic        cond_max, cond_min, cond_rise, cond_fall;
   logic signed [37:0] n_in;
   logic signed [37:0] root_s;
   logic [32:0] prod;
   logic signed [34:0] off;
   logic signed [34:0] place_sum;
   logic signed [DATA_WIDTH-1:0] place_sat;

   scel_iter_unit u_iter (
      .clock     (clock),
      .reset     (reset),
      .iu_cmd    (iu_cmd_ff),
      .iu_opa    (iu_opa_ff),
      .iu_opb    (iu_opb_ff),
      .iu_done   (iu_done),
      .iu_result (iu_result)
   );

   // Parabola coefficients in doubled units and the sample step.
   always_comb begin
      a2_in = 35'(older_y_ff) + 35'(y2_ff) - (35'(middle_y_ff) <<< 1);
      b2_in = 34'(y2_ff) - 34'(older_y_ff);
      dx_in = 33'(middle_x_ff) - 33'(older_x_ff);
   end

   // Magnitudes, window tests and the discriminant arithmetic.
   always_comb begin
      a2_mag    = a2_ff[34] ? 35'(-a2_ff) : 35'(a2_ff);
      b2_mag    = b2_ff[33] ? 34'(-b2_ff) : 34'(b2_ff);
      dx_mag    = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      y1_mag    = middle_y_ff[31] ? 32'(-middle_y_ff) : 32'(middle_y_ff);
      den       = {a2_mag, 1'b0};
      r1_mag    = r1_ff[37] ? 38'(-r1_ff) : 38'(r1_ff);
      r2_mag    = r2_ff[37] ? 38'(-r2_ff) : 38'(r2_ff);
      window_ok = (samples_seen_ff == 2'd2) && (events_found_ff < limit_ff);
      cond_max  = (older_y_ff < middle_y_ff) && (y2_ff < middle_y_ff);
      cond_min  = (older_y_ff > middle_y_ff) && (y2_ff > middle_y_ff);
      cond_rise = (older_y_ff < 0) && (middle_y_ff <= 0) && (y2_ff > 0);
      cond_fall = (older_y_ff > 0) && (middle_y_ff >= 0) && (y2_ff < 0);
      same_sign = ((a2_ff > 0) && (middle_y_ff > 0)) || ((a2_ff < 0) && (middle_y_ff < 0));
      d_diff    = {1'b0, d_ff} - {1'b0, iu_result};
      d_sum     = d_ff + iu_result;
      n_in      = (a2_ff > 0) ? -38'(b2_ff) : 38'(b2_ff);
      root_s    = $signed({2'b00, iu_result[ROOT_W-1:0]});
      prod      = iu_result[FRAC_BITS +: 33];
      off       = (tneg_ff != dx_ff[32]) ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
      place_sum = 35'(middle_x_ff) + off;
      if (place_sum > 35'sd2147483647) begin
         place_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else if (place_sum < -35'sd2147483648) begin
         place_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         place_sat = place_sum[DATA_WIDTH-1:0];
      end
   end

   // Sequencer, window, configuration and output register.
   always_ff @(posedge clock) begin
      iu_cmd_ff.start <= 1'b0;
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= MODE_MAXIMA;
         limit_ff        <= COUNT_W'(64);
         events_found_ff <= '0;
         samples_seen_ff <= '0;
         older_x_ff      <= '0;
         older_y_ff      <= '0;
         middle_x_ff     <= '0;
         middle_y_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         iu_cmd_ff       <= '{start: 1'b0, op: IU_MUL};
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_DETECT_MODE) begin
               mode_ff <= detect_mode_type'(csr_write_data[1:0]);
            end else if (csr_index == CSR_RESULT_LIMIT) begin
               limit_ff <= csr_write_data;
            end
         end
         // The output register empties on acceptance unless a new event refills it.
         if (rsp_valid_ff && rsp_ready && !((state_ff == ST_FINISH) && hit_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  x2_ff    <= req_x_value;
                  y2_ff    <= req_y_value;
                  last_ff  <= req_last_sample;
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               a2_ff    <= a2_in;
               b2_ff    <= b2_in;
               dx_ff    <= dx_in;
               hit_ff   <= 1'b0;
               tneg_ff  <= 1'b0;
               tq_ff    <= '0;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               state_ff <= ST_FINISH;
               if (window_ok) begin
                  if (((mode_ff == MODE_MAXIMA) && cond_max) ||
                      ((mode_ff == MODE_MINIMA) && cond_min)) begin
                     hit_ff <= 1'b1;
                     if (a2_ff == '0) begin
                        state_ff <= ST_PLACE;
                     end else begin
                        tneg_ff   <= (b2_ff != '0) && ((b2_ff > 0) == (a2_ff > 0));
                        iu_cmd_ff <= '{start: 1'b1, op: IU_DIV};
                        iu_opa_ff <= WIDE_W'(b2_mag);
                        iu_opb_ff <= den;
                        state_ff  <= ST_DIV;
                     end
                  end else if (((mode_ff == MODE_RISING) && cond_rise) ||
                               ((mode_ff == MODE_FALLING) && cond_fall)) begin
                     iu_cmd_ff <= '{start: 1'b1, op: IU_MUL};
                     iu_opa_ff <= WIDE_W'(b2_mag);
                     iu_opb_ff <= OPB_W'(b2_mag);
                     state_ff  <= ST_MUL_B;
                  end
               end
            end
            ST_MUL_B: begin
               if (iu_done) begin
                  d_ff      <= iu_result;
                  iu_cmd_ff <= '{start: 1'b1, op: IU_MUL};
                  iu_opa_ff <= WIDE_W'({a2_mag, 3'b000});
                  iu_opb_ff <= OPB_W'(y1_mag);
                  state_ff  <= ST_MUL_AC;
               end
            end
            ST_MUL_AC: begin
               if (iu_done) begin
                  if (same_sign && d_diff[WIDE_W]) begin
                     // Negative discriminant: no crossing.
                     state_ff <= ST_FINISH;
                  end else begin
                     hit_ff <= 1'b1;
                     if (a2_ff == '0) begin
                        state_ff <= ST_PLACE;
                     end else begin
                        iu_cmd_ff <= '{start: 1'b1, op: IU_SQRT};
                        iu_opa_ff <= same_sign ? d_diff[WIDE_W-1:0] : d_sum;
                        state_ff  <= ST_SQRT;
                     end
                  end
               end
            end
            ST_SQRT: begin
               if (iu_done) begin
                  r2_ff    <= n_in + root_s;
                  r1_ff    <= n_in - root_s;
                  state_ff <= ST_ROOTS;
               end
            end
            ST_ROOTS: begin
               // Prefer the larger root when it lies strictly within one step.
               if (r2_mag < 38'(den)) begin
                  tneg_ff   <= r2_ff[37];
                  iu_cmd_ff <= '{start: 1'b1, op: IU_DIV};
                  iu_opa_ff <= WIDE_W'(r2_mag);
                  iu_opb_ff <= den;
                  state_ff  <= ST_DIV;
               end else if (r1_mag < 38'(den)) begin
                  tneg_ff   <= r1_ff[37];
                  iu_cmd_ff <= '{start: 1'b1, op: IU_DIV};
                  iu_opa_ff <= WIDE_W'(r1_mag);
                  iu_opb_ff <= den;
                  state_ff  <= ST_DIV;
               end else begin
                  state_ff <= ST_PLACE;
               end
            end
            ST_DIV: begin
               if (iu_done) begin
                  tq_ff    <= iu_result[FRAC_BITS-1:0];
                  state_ff <= ST_PLACE;
               end
            end
            ST_PLACE: begin
               iu_cmd_ff <= '{start: 1'b1, op: IU_MUL};
               iu_opa_ff <= WIDE_W'(dx_mag);
               iu_opb_ff <= OPB_W'(tq_ff);
               state_ff  <= ST_PLACE_MUL;
            end
            ST_PLACE_MUL: begin
               if (iu_done) begin
                  place_x_ff <= place_sat;
                  state_ff   <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Wait for a free output register before handing over an event.
               if (!hit_ff || !rsp_valid_ff || rsp_ready) begin
                  if (hit_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_x_ff     <= place_x_ff;
                     rsp_count_ff <= events_found_ff + COUNT_W'(1);
                  end
                  if (last_ff) begin
                     older_x_ff      <= '0;
                     older_y_ff      <= '0;
                     middle_x_ff     <= '0;
                     middle_y_ff     <= '0;
                     samples_seen_ff <= '0;
                     events_found_ff <= '0;
                  end else begin
                     if (hit_ff) begin
                        events_found_ff <= events_found_ff + COUNT_W'(1);
                     end
                     older_x_ff  <= middle_x_ff;
                     older_y_ff  <= middle_y_ff;
                     middle_x_ff <= x2_ff;
                     middle_y_ff <= y2_ff;
                     if (samples_seen_ff != 2'd2) begin
                        samples_seen_ff <= samples_seen_ff + 2'd1;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_x     = rsp_x_ff;
   assign rsp_event_count = rsp_count_ff;

endmodule

`default_nettype wire

>>> design/scel_iter_unit.sv
`default_nettype none

module scel_iter_unit import scel_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  iu_cmd_type        iu_cmd,
   input  logic [WIDE_W-1:0] iu_opa,
   input  logic [OPB_W-1:0]  iu_opb,
   output logic              iu_done,
   output logic [WIDE_W-1:0] iu_result
);

   logic              busy_ff;
   logic              done_ff;
   iu_op_type         op_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WIDE_W-1:0] acc_ff;
   logic [WIDE_W-1:0] aux_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] q_ff;

   logic [REM_W-1:0]  sqrt_rem_in;
   logic [REM_W-1:0]  sqrt_trial;
   logic [REM_W-1:0]  div_rem_in;

   // Operands of one square root or division step.
   assign sqrt_rem_in = {rem_ff[REM_W-3:0], aux_ff[WIDE_W-1 -: 2]};
   assign sqrt_trial  = {2'b00, q_ff, 2'b01};
   assign div_rem_in  = {rem_ff[REM_W-2:0], 1'b0};

   // One multiply, root or divide step per cycle.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (iu_cmd.start) begin
         busy_ff <= 1'b1;
         op_ff   <= iu_cmd.op;
         acc_ff  <= '0;
         q_ff    <= '0;
         rem_ff  <= '0;
         aux_ff  <= iu_opa;
         case (iu_cmd.op)
            IU_MUL: begin
               q_ff <= iu_opb;
            end
            IU_SQRT: begin
               cnt_ff <= CNT_W'(ROOT_W - 1);
            end
            IU_DIV: begin
               rem_ff <= iu_opa[REM_W-1:0];
               aux_ff <= WIDE_W'(iu_opb);
               cnt_ff <= CNT_W'(FRAC_BITS - 1);
            end
            default: begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            IU_MUL: begin
               // Shift-add multiply; stops once the multiplier runs out of ones.
               if (q_ff == '0) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  if (q_ff[0]) begin
                     acc_ff <= acc_ff + aux_ff;
                  end
                  aux_ff <= {aux_ff[WIDE_W-2:0], 1'b0};
                  q_ff   <= {1'b0, q_ff[ROOT_W-1:1]};
               end
            end
            IU_SQRT: begin
               // Restoring square root, two radicand bits per step.
               if (sqrt_rem_in >= sqrt_trial) begin
                  rem_ff <= sqrt_rem_in - sqrt_trial;
                  q_ff   <= {q_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= sqrt_rem_in;
                  q_ff   <= {q_ff[ROOT_W-2:0], 1'b0};
               end
               aux_ff <= {aux_ff[WIDE_W-3:0], 2'b00};
               if (cnt_ff == '0) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            IU_DIV: begin
               // Restoring fraction divide, one quotient bit per step.
               if (div_rem_in >= aux_ff[REM_W-1:0]) begin
                  rem_ff <= div_rem_in - aux_ff[REM_W-1:0];
                  q_ff   <= {q_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= div_rem_in;
                  q_ff   <= {q_ff[ROOT_W-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            default: begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         endcase
      end
   end

   assign iu_done   = done_ff;
   assign iu_result = (op_ff == IU_MUL) ? acc_ff : WIDE_W'(q_ff);

endmodule

`default_nettype wire

>>> design/scel_checker.sv
`default_nettype none

module scel_checker import scel_pkg::*; (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic signed [DATA_WIDTH-1:0] rsp_event_x,
   input wire logic [COUNT_W-1:0]           rsp_event_count
);

   // A waiting event holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_x)
         && $stable(rsp_event_count))
      else $error("event changed while stalled");

   // Event ordinals start at one.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_count != '0)
      else $error("event count of zero");

   // An accepted item leaves the block not ready in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // Reset leaves no event pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event pending after reset");

endmodule

bind sampled_curve_event_locator_top scel_checker u_scel_checker (.*);

`default_nettype wire
